// ===== sv/nag_pkg.sv =====
// Shared types and constants for the normal arrow geometry block.
// Used by normal_arrow_geometry; depends on nothing.
package nag_pkg;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SQ    = 8'b0000_0010,
        ST_SQRT  = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_PERP  = 8'b0001_0000,
        ST_SCALE = 8'b0010_0000,
        ST_GEOM  = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_NORM = 3'b001,
        PH_PERP = 3'b010,
        PH_DIAG = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        REG_DIM   = 2'd0,
        REG_SHAFT = 2'd1,
        REG_HLEN  = 2'd2,
        REG_HWID  = 2'd3
    } reg_idx_t;

    localparam logic       CMD_NODE      = 1'b0;
    localparam logic [1:0] DIM_PLANAR    = 2'd2;
    localparam logic [1:0] DIM_RESET     = 2'd3;
    localparam logic [15:0] SHAFT_RESET  = 16'd2621;
    localparam logic [15:0] HLEN_RESET   = 16'd20972;
    localparam logic [15:0] HWID_RESET   = 16'd11796;
    localparam logic [32:0] ONE_Q16      = 33'd65536;
    localparam logic [65:0] DEGEN_LIMIT  = 66'd512;
    localparam logic [16:0] PERP_SWITCH  = 17'd58982;
    localparam logic [65:0] ROUND_HALF   = 66'd32768;
    localparam logic signed [31:0] BOX_LOW_RESET  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] BOX_HIGH_RESET = 32'sh8000_0000;
    localparam logic [5:0] SQRT_STEPS    = 6'd33;
    localparam logic [5:0] DIV_STEPS     = 6'd18;
    localparam logic [5:0] SQ_DONE       = 6'd4;
    localparam logic [5:0] SCALE_DONE    = 6'd4;
    localparam logic [5:0] GEOM_DONE     = 6'd9;

endpackage

// ===== sv/normal_arrow_geometry.sv =====
// Normal arrow geometry generator: bounding box, normalization and arrow segments.
// Depends on nag_pkg.
//
// Node transfers widen the bounding box. A face transfer runs through one shared
// 33x33 multiplier, one bit-serial square root (33 steps) and one restoring divider (17 steps
// per component) under a sequencer: a non-degenerate face takes up to three square roots and
// six divisions (the box diagonal root is skipped while no node has been seen) before the
// first segment is offered. A degenerate face is dropped without output. No transfer is
// taken while a face is in work.
module normal_arrow_geometry #(
    parameter int COORD_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import nag_pkg::*;

    localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (SAT_BITS - 1)) - 40'sd1;
    localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

    state_t state_reg;
    phase_t phase_reg;
    logic [5:0] cnt_reg;
    logic [1:0] comp_reg;
    logic [1:0] sub_reg;
    logic [1:0] seg_reg;

    logic [1:0]  dim_reg;
    logic [15:0] shaft_reg;
    logic [15:0] hlen_reg;
    logic [15:0] hwid_reg;

    logic signed [31:0] box_lo_reg [3];
    logic signed [31:0] box_hi_reg [3];
    logic seen_reg;

    logic signed [31:0] c_reg [3];
    logic signed [31:0] n_reg [3];
    logic signed [17:0] u_reg [3];
    logic signed [17:0] p_reg [3];
    logic signed [17:0] q_reg [3];
    logic signed [39:0] tip_reg [3];
    logic signed [39:0] e1_reg [3];
    logic signed [39:0] e2_reg [3];

    logic [65:0] acc_reg;
    logic [65:0] prod_reg;
    logic [65:0] rad_reg;
    logic [35:0] rem_reg;
    logic [32:0] root_reg;
    logic [48:0] num_reg;
    logic [48:0] dsh_reg;
    logic [16:0] quo_reg;
    logic [31:0] len_reg;
    logic        dneg_reg;
    logic [32:0] diag_reg;
    logic [32:0] s_reg;
    logic [32:0] hl_reg;
    logic [32:0] hw_reg;
    logic [1:0]  tag_i_reg;
    logic [1:0]  tag_j_reg;
    logic        tag_neg_reg;

    logic        planar;
    logic        in_fire;
    logic        out_fire;
    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic        mul_neg;
    logic [31:0] sq_op;
    logic signed [32:0] diff [3];
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic signed [31:0] div_src;
    logic [65:0] prod_rnd;
    logic signed [39:0] m_signed;
    logic signed [31:0] in_pos [3];
    logic signed [31:0] in_dir [3];
    logic signed [39:0] seg_a [3];
    logic signed [39:0] seg_b [3];

    function automatic logic [31:0] mag32(logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [16:0] mag18(logic signed [17:0] v);
        return v[17] ? 17'(-v) : v[16:0];
    endfunction

    function automatic logic [31:0] sat(logic signed [39:0] v);
        logic signed [39:0] r;
        r = v;
        if (v > SAT_HI)
            r = SAT_HI;
        else if (v < SAT_LO)
            r = SAT_LO;
        return r[31:0];
    endfunction

    assign planar    = (dim_reg == DIM_PLANAR);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_EMIT);
    assign m_tlast   = (seg_reg == 2'd2);
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_pos[k] = s_tdata[32*k +: 32];
            in_dir[k] = s_tdata[96 + 32*k +: 32];
            diff[k]   = {box_hi_reg[k][31], box_hi_reg[k]} - {box_lo_reg[k][31], box_lo_reg[k]};
        end
        if (planar)
        begin
            in_pos[2] = '0;
            in_dir[2] = '0;
        end
    end

    always_comb
    begin
        sq_op = '0;
        unique case (cnt_reg)
            6'd0, 6'd1, 6'd2:
            begin
                unique case (phase_reg)
                    PH_NORM: sq_op = mag32(n_reg[cnt_reg[1:0]]);
                    PH_PERP: sq_op = {15'd0, mag18(p_reg[cnt_reg[1:0]])};
                    PH_DIAG: sq_op = diff[cnt_reg[1:0]][31:0];
                    default: sq_op = '0;
                endcase
            end
            default: sq_op = '0;
        endcase
    end

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = {1'b0, sq_op};
                mul_b = {1'b0, sq_op};
            end
            ST_SCALE:
            begin
                unique case (cnt_reg)
                    6'd0:
                    begin
                        mul_a = diag_reg;
                        mul_b = {17'd0, shaft_reg};
                    end
                    6'd2:
                    begin
                        mul_a = s_reg;
                        mul_b = {17'd0, hlen_reg};
                    end
                    6'd3:
                    begin
                        mul_a = s_reg;
                        mul_b = {17'd0, hwid_reg};
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_GEOM:
            begin
                unique case (sub_reg)
                    2'd0:
                    begin
                        mul_a   = {16'd0, mag18(u_reg[comp_reg])};
                        mul_b   = s_reg;
                        mul_neg = u_reg[comp_reg][17];
                    end
                    2'd1:
                    begin
                        mul_a   = {16'd0, mag18(u_reg[comp_reg])};
                        mul_b   = hl_reg;
                        mul_neg = u_reg[comp_reg][17];
                    end
                    default:
                    begin
                        mul_a   = {16'd0, mag18(q_reg[comp_reg])};
                        mul_b   = hw_reg;
                        mul_neg = q_reg[comp_reg][17];
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rem_sh   = {rem_reg[33:0], rad_reg[65:64]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign div_src  = (phase_reg == PH_NORM) ? n_reg[comp_reg]
                                             : {{14{p_reg[comp_reg][17]}}, p_reg[comp_reg]};
    assign prod_rnd = prod_reg + ROUND_HALF;
    assign m_signed = tag_neg_reg ? -$signed({5'd0, prod_rnd[50:16]})
                                  : $signed({5'd0, prod_rnd[50:16]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NORM;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            sub_reg   <= '0;
            seg_reg   <= '0;
            dim_reg   <= DIM_RESET;
            shaft_reg <= SHAFT_RESET;
            hlen_reg  <= HLEN_RESET;
            hwid_reg  <= HWID_RESET;
            seen_reg  <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                box_lo_reg[k] <= BOX_LOW_RESET;
                box_hi_reg[k] <= BOX_HIGH_RESET;
            end
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DIM:   dim_reg   <= cfg_data[1:0];
                    REG_SHAFT: shaft_reg <= cfg_data;
                    REG_HLEN:  hlen_reg  <= cfg_data;
                    REG_HWID:  hwid_reg  <= cfg_data;
                    default:   dim_reg   <= dim_reg;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_tuser == CMD_NODE)
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                if (in_pos[k] < box_lo_reg[k])
                                    box_lo_reg[k] <= in_pos[k];
                                if (in_pos[k] > box_hi_reg[k])
                                    box_hi_reg[k] <= in_pos[k];
                            end
                            seen_reg <= 1'b1;
                        end
                        else
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                c_reg[k] <= in_pos[k];
                                n_reg[k] <= in_dir[k];
                            end
                            phase_reg <= PH_NORM;
                            cnt_reg   <= '0;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd0)
                        acc_reg <= '0;
                    else
                        acc_reg <= acc_reg + prod_reg;
                    if (cnt_reg == SQ_DONE)
                    begin
                        rad_reg  <= acc_reg;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= '0;
                        state_reg <= ST_SQRT;
                        if (phase_reg == PH_NORM && acc_reg <= DEGEN_LIMIT)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (phase_reg == PH_PERP && acc_reg == '0)
                        begin
                            q_reg[0] <= 18'sd65536;
                            q_reg[1] <= '0;
                            q_reg[2] <= '0;
                            phase_reg <= PH_DIAG;
                            if (!seen_reg)
                            begin
                                diag_reg  <= ONE_Q16;
                                state_reg <= ST_SCALE;
                            end
                            else
                            begin
                                state_reg <= ST_SQ;
                            end
                        end
                    end
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg < SQRT_STEPS)
                    begin
                        rad_reg <= {rad_reg[63:0], 2'b00};
                        if (rem_sh >= trial)
                        begin
                            rem_reg  <= rem_sh - trial;
                            root_reg <= {root_reg[31:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= rem_sh;
                            root_reg <= {root_reg[31:0], 1'b0};
                        end
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        if (phase_reg == PH_DIAG)
                        begin
                            diag_reg  <= (root_reg == '0) ? ONE_Q16 : root_reg;
                            state_reg <= ST_SCALE;
                        end
                        else
                        begin
                            len_reg   <= root_reg[31:0];
                            comp_reg  <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        num_reg  <= 49'({mag32(div_src), 16'd0}) + 49'(len_reg[31:1]);
                        dsh_reg  <= 49'({len_reg, 16'd0});
                        quo_reg  <= '0;
                        dneg_reg <= div_src[31];
                    end
                    else if (cnt_reg < DIV_STEPS)
                    begin
                        dsh_reg <= {1'b0, dsh_reg[48:1]};
                        if (num_reg >= dsh_reg)
                        begin
                            num_reg <= num_reg - dsh_reg;
                            quo_reg <= {quo_reg[15:0], 1'b1};
                        end
                        else
                        begin
                            quo_reg <= {quo_reg[15:0], 1'b0};
                        end
                    end
                    else
                    begin
                        cnt_reg  <= '0;
                        comp_reg <= comp_reg + 2'd1;
                        if (phase_reg == PH_NORM)
                            u_reg[comp_reg] <= dneg_reg ? -$signed({1'b0, quo_reg})
                                                        : $signed({1'b0, quo_reg});
                        else
                            q_reg[comp_reg] <= dneg_reg ? -$signed({1'b0, quo_reg})
                                                        : $signed({1'b0, quo_reg});
                        if (comp_reg == 2'd2)
                        begin
                            if (phase_reg == PH_NORM)
                            begin
                                state_reg <= ST_PERP;
                            end
                            else
                            begin
                                phase_reg <= PH_DIAG;
                                if (!seen_reg)
                                begin
                                    diag_reg  <= ONE_Q16;
                                    state_reg <= ST_SCALE;
                                end
                                else
                                begin
                                    state_reg <= ST_SQ;
                                end
                            end
                        end
                    end
                end
                ST_PERP:
                begin
                    if (planar)
                    begin
                        p_reg[0] <= -u_reg[1];
                        p_reg[1] <= u_reg[0];
                        p_reg[2] <= '0;
                    end
                    else if (mag18(u_reg[0]) <= PERP_SWITCH)
                    begin
                        p_reg[0] <= '0;
                        p_reg[1] <= u_reg[2];
                        p_reg[2] <= -u_reg[1];
                    end
                    else
                    begin
                        p_reg[0] <= -u_reg[2];
                        p_reg[1] <= '0;
                        p_reg[2] <= u_reg[0];
                    end
                    phase_reg <= PH_PERP;
                    cnt_reg   <= '0;
                    state_reg <= ST_SQ;
                end
                ST_SCALE:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd1)
                        s_reg <= prod_rnd[48:16];
                    if (cnt_reg == 6'd3)
                        hl_reg <= prod_rnd[48:16];
                    if (cnt_reg == SCALE_DONE)
                    begin
                        hw_reg    <= prod_rnd[48:16];
                        cnt_reg   <= '0;
                        comp_reg  <= '0;
                        sub_reg   <= '0;
                        state_reg <= ST_GEOM;
                    end
                end
                ST_GEOM:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg < GEOM_DONE)
                    begin
                        tag_i_reg   <= comp_reg;
                        tag_j_reg   <= sub_reg;
                        tag_neg_reg <= mul_neg;
                        if (sub_reg == 2'd2)
                        begin
                            sub_reg  <= '0;
                            comp_reg <= comp_reg + 2'd1;
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 2'd1;
                        end
                    end
                    if (cnt_reg != 6'd0)
                    begin
                        unique case (tag_j_reg)
                            2'd0:
                                tip_reg[tag_i_reg] <= 40'(c_reg[tag_i_reg]) + m_signed;
                            2'd1:
                            begin
                                e1_reg[tag_i_reg] <= tip_reg[tag_i_reg] - m_signed;
                                e2_reg[tag_i_reg] <= tip_reg[tag_i_reg] - m_signed;
                            end
                            default:
                            begin
                                e1_reg[tag_i_reg] <= e1_reg[tag_i_reg] + m_signed;
                                e2_reg[tag_i_reg] <= e2_reg[tag_i_reg] - m_signed;
                            end
                        endcase
                    end
                    if (cnt_reg == GEOM_DONE)
                    begin
                        seg_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_fire)
                    begin
                        if (seg_reg == 2'd2)
                            state_reg <= ST_IDLE;
                        else
                            seg_reg <= seg_reg + 2'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            unique case (seg_reg)
                2'd0:
                begin
                    seg_a[k] = 40'(c_reg[k]);
                    seg_b[k] = tip_reg[k];
                end
                2'd1:
                begin
                    seg_a[k] = tip_reg[k];
                    seg_b[k] = e1_reg[k];
                end
                default:
                begin
                    seg_a[k] = tip_reg[k];
                    seg_b[k] = e2_reg[k];
                end
            endcase
        end
    end

    assign m_tdata = {sat(seg_b[2]), sat(seg_b[1]), sat(seg_b[0]),
                      sat(seg_a[2]), sat(seg_a[1]), sat(seg_a[0])};

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input and output sides active together");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not ready after last segment transfer");

    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (seg_reg == 2'd0))
        else $error("arrow emission did not start at shaft segment");

endmodule

// ===== verif/tb_normal_arrow_geometry.sv =====
// Self-checking testbench for normal_arrow_geometry: node and face transfers in,
// arrow segments out, each compared against an in-bench arrow predictor.
// Depends on nag_pkg and normal_arrow_geometry.
`timescale 1ns / 1ps

module tb_normal_arrow_geometry;
    import nag_pkg::*;

    localparam int  LIMIT_CYCLES = 1000000;
    localparam int  SETTLE       = 300;
    localparam logic CMD_FACE    = 1'b1;

    typedef struct packed {
        logic [191:0] pts;
        logic         last;
    } segment_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    segment_t segments_due[$];
    int       errors = 0;
    int       cycles = 0;
    int       burst_left = 0;
    int       stall_pct = 0;
    bit       hold_req = 0;
    logic     hold_rx = 1'b0;

    logic [1:0]  dim_mode = DIM_RESET;
    logic [15:0] shaft_frac = SHAFT_RESET;
    logic [15:0] head_len = HLEN_RESET;
    logic [15:0] head_wid = HWID_RESET;
    longint      box_lo[3];
    longint      box_hi[3];
    bit          node_seen = 0;

    string field_names[7] = '{"start_x", "start_y", "start_z", "end_x", "end_y", "end_z",
                              "last"};

    normal_arrow_geometry dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
        .s_tuser  (s_tuser),    // cmd
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // start_x, start_y, start_z, end_x, end_y, end_z
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit square_fits(longint unsigned t, longint unsigned a,
                                       longint unsigned b);
        longint unsigned k = t >> 1;
        longint unsigned c = t & 1;
        longint unsigned x = k * k + (c != 0 ? k : 0);
        if (b >= c)
            return x <= a + (b - c) / 4;
        return x + 1 <= a;
    endfunction

    function automatic longint mul_q16(longint a, longint b);
        longint unsigned m = (mag(a) * mag(b) + 32768) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unit_q16(longint c, longint unsigned len);
        longint unsigned m = ((mag(c) << 16) + len / 2) / len;
        return c < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic longint unsigned box_diagonal();
        longint unsigned a = 0;
        longint unsigned b = 0;
        longint unsigned r;
        longint unsigned d;
        if (!node_seen)
            return 65536;
        for (int i = 0; i < 3; i++)
        begin
            d = longint'(box_hi[i] - box_lo[i]);
            a += (d * d) >> 2;
            b += (d * d) & 3;
        end
        r = 2 * isqrt(a);
        while (square_fits(r + 1, a, b))
            r++;
        return r == 0 ? 65536 : r;
    endfunction

    task automatic predict_arrow(input logic cmd, input logic [191:0] d);
        longint c[3], n[3], u[3], p[3], q[3], tip[3], e1[3], e2[3];
        longint unsigned sn, sp, len, s, hl, hw;
        longint back, barb;
        bit planar;
        segment_t seg;
        planar = (dim_mode == DIM_PLANAR);
        sn = 0;
        sp = 0;
        for (int i = 0; i < 3; i++)
        begin
            c[i] = longint'($signed(d[32*i +: 32]));
            n[i] = longint'($signed(d[96 + 32*i +: 32]));
        end
        if (planar)
        begin
            c[2] = 0;
            n[2] = 0;
        end
        if (cmd == CMD_NODE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (c[i] < box_lo[i]) box_lo[i] = c[i];
                if (c[i] > box_hi[i]) box_hi[i] = c[i];
            end
            node_seen = 1;
            return;
        end
        for (int i = 0; i < 3; i++)
            sn += mag(n[i]) * mag(n[i]);
        if (sn <= 512)
            return;
        len = isqrt(sn);
        for (int i = 0; i < 3; i++)
            u[i] = unit_q16(n[i], len);
        if (planar)
        begin
            p[0] = -u[1]; p[1] = u[0]; p[2] = 0;
        end
        else if (mag(u[0]) <= 58982)
        begin
            p[0] = 0; p[1] = u[2]; p[2] = -u[1];
        end
        else
        begin
            p[0] = -u[2]; p[1] = 0; p[2] = u[0];
        end
        for (int i = 0; i < 3; i++)
            sp += mag(p[i]) * mag(p[i]);
        if (sp == 0)
        begin
            q[0] = 65536; q[1] = 0; q[2] = 0;
        end
        else
        begin
            len = isqrt(sp);
            for (int i = 0; i < 3; i++)
                q[i] = unit_q16(p[i], len);
        end
        s  = (box_diagonal() * longint'(shaft_frac) + 32768) >> 16;
        hl = (s * longint'(head_len) + 32768) >> 16;
        hw = (s * longint'(head_wid) + 32768) >> 16;
        for (int i = 0; i < 3; i++)
        begin
            tip[i] = c[i] + mul_q16(u[i], longint'(s));
            back = tip[i] - mul_q16(u[i], longint'(hl));
            barb = mul_q16(q[i], longint'(hw));
            e1[i] = back + barb;
            e2[i] = back - barb;
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                seg.pts[32*i +: 32] = clamp32(k == 0 ? c[i] : tip[i]);
                seg.pts[96 + 32*i +: 32] = clamp32(k == 0 ? tip[i] : (k == 1 ? e1[i] : e2[i]));
            end
            seg.last = (k == 2);
            segments_due = {segments_due, seg};
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    endtask

    // check outputs, drive the receiver stall pattern
    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (segments_due.size() == 0)
                    report("unexpected segment", m_tdata[31:0], '0);
                else
                begin
                    want = segments_due.pop_front();
                    for (int f = 0; f < 6; f++)
                        if (m_tdata[32*f +: 32] !== want.pts[32*f +: 32])
                            report(field_names[f], m_tdata[32*f +: 32], want.pts[32*f +: 32]);
                    if (m_tlast !== want.last)
                        report(field_names[6], 32'(m_tlast), 32'(want.last));
                end
            end
            if (cycles % 97 == 0)
                stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            m_tready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_rx <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_rx <= 1'b0;
                hold_req = 0;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [191:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        predict_arrow(cmd, data);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 260) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (segments_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] dim, input logic [15:0] shaft,
                              input logic [15:0] hlen, input logic [15:0] hwid);
        logic [15:0] vals[4];
        vals = '{{14'($urandom_range(0, 16383)), dim}, shaft, hlen, hwid};
        drain();
        cfg_valid <= 1'b1;
        for (int r = 0; r < 4; r++)
        begin
            cfg_index <= r[1:0];
            cfg_data  <= vals[r];
            do @(posedge clk); while (!cfg_ready);
            case (reg_idx_t'(r[1:0]))
                REG_DIM:   dim_mode = vals[r][1:0];
                REG_SHAFT: shaft_frac = vals[r];
                REG_HLEN:  head_len = vals[r];
                REG_HWID:  head_wid = vals[r];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [191:0] pack_item(longint px, longint py, longint pz,
                                               longint dx, longint dy, longint dz);
        return {dz[31:0], dy[31:0], dx[31:0], pz[31:0], py[31:0], px[31:0]};
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed({1'b0, $urandom_range(0, 1 << 22)}) - (1 << 21));
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return 32'($signed({1'b0, $urandom_range(0, 40)}) - 20);
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'h0;
            default: return 32'($signed({1'b0, $urandom_range(0, 1 << 19)}) - (1 << 18));
        endcase
    endfunction

    task automatic send_random(input int count, input int node_pct);
        logic [31:0] v[6];
        for (int k = 0; k < count; k++)
        begin
            for (int f = 0; f < 3; f++)
            begin
                v[f] = rand_coord();
                v[3 + f] = rand_dir();
            end
            send_item(($urandom_range(0, 99) < node_pct) ? CMD_NODE : CMD_FACE,
                      {v[5], v[4], v[3], v[2], v[1], v[0]});
        end
    endtask

    task automatic test_no_nodes();
        send_item(CMD_FACE, pack_item(0, 0, 0, 65536, 0, 0));
        send_item(CMD_FACE, pack_item(100, -200, 300, 0, 0, -65536));
        send_item(CMD_FACE, pack_item(0, 0, 0, 16, 16, 0));
        send_item(CMD_FACE, pack_item(0, 0, 0, 16, 16, 1));
        send_item(CMD_FACE, pack_item(5, 5, 5, 0, 0, 0));
    endtask

    task automatic test_directed_extremes();
        send_item(CMD_NODE, pack_item(0, 0, 0, 0, 0, 0));
        send_item(CMD_FACE, pack_item(0, 0, 0, 0, 65536, 0));
        send_item(CMD_NODE, pack_item(65536, 131072, -65536, 0, 0, 0));
        send_item(CMD_FACE, pack_item(1000, 2000, 3000, 58982, 28567, 0));
        send_item(CMD_FACE, pack_item(1000, 2000, 3000, 58983, 28565, 0));
        send_item(CMD_FACE, pack_item(0, 0, 0, 2147483647, 1, 0));
        send_item(CMD_FACE, pack_item(0, 0, 0, -2147483648, -2147483648, -2147483648));
        send_item(CMD_NODE, pack_item(2147483647, 2147483647, 2147483647, -1, -1, -1));
        send_item(CMD_NODE, pack_item(-2147483648, -2147483648, -2147483648, 0, 0, 0));
        send_item(CMD_FACE, pack_item(2147483647, 2147483647, 2147483647, 1, 1, 1));
        send_item(CMD_FACE, pack_item(-2147483648, -2147483648, -2147483648, -1, -1, -1));
        send_item(CMD_FACE, pack_item(0, 0, 0, 2147483647, 2147483647, 2147483647));
        set_config(DIM_PLANAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_FACE, pack_item(0, 0, 123456, 0, 23, 777));
        send_item(CMD_FACE, pack_item(-7, 9, 0, -65536, -65536, 5));
        send_item(CMD_FACE, pack_item(0, 0, 0, 0, 0, 2147483647));
        set_config(2'd0, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_FACE, pack_item(1, 2, 3, 3, 4, 5));
        set_config(2'd1, 16'h8000, 16'h4000, 16'h2000);
        send_item(CMD_FACE, pack_item(1, 2, 3, -3, 4, -5));
    endtask

    task automatic test_config_sweep();
        set_config(DIM_RESET, SHAFT_RESET, HLEN_RESET, HWID_RESET);
        send_random(120, 30);
        set_config(DIM_PLANAR, 16'($urandom), 16'($urandom), 16'($urandom));
        send_random(100, 30);
        set_config(2'd1, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_random(60, 25);
        set_config(2'd0, 16'($urandom), 16'($urandom), 16'($urandom));
        send_random(80, 30);
        set_config(DIM_RESET, 16'h0000, 16'hFFFF, 16'h0000);
        send_random(40, 20);
    endtask

    task automatic test_backpressure();
        set_config(DIM_RESET, 16'd6554, 16'd20000, 16'd12000);
        hold_req = 1;
        send_random(40, 20);
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = longint'(BOX_LOW_RESET);
            box_hi[i] = longint'(BOX_HIGH_RESET);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_nodes();
        test_directed_extremes();
        test_config_sweep();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
